// ===== design/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared constants and types for the trial division prime test.
// ----------------------------------------------------------------------------
package tdpt_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CANDIDATE_WIDTH     = 32;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_status_t;

endpackage

// ===== design/tdpt_rem.sv =====
// ----------------------------------------------------------------------------
// tdpt_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdpt_rem #(
  parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [VALUE_WIDTH-1:0]   dividend,
  input  logic [VALUE_WIDTH-1:0]   divisor,
  output tdpt_pkg::rem_status_t    status
);
  import tdpt_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] shreg;
  logic [VALUE_WIDTH-1:0] rem;
  logic [VALUE_WIDTH-1:0] dvs;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   done;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH:0]   rem_next;

  always_comb begin
    trial = {rem, shreg[VALUE_WIDTH-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = trial - {1'b0, dvs};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(VALUE_WIDTH);
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= rem_next[VALUE_WIDTH-1:0];
        shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
        cnt   <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

// ===== design/trial_division_prime_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality of one unsigned candidate per word by trial division.
// ----------------------------------------------------------------------------
// Each accepted candidate word, reduced to its low VALUE_WIDTH bits, yields one
// is_prime word. Candidates 0 and 1 go straight to the done state. Otherwise
// divisors d = 2, 3, ... with d*d <= n are tried in turn until one divides n;
// each try is a bound check in the check state followed by a pass through the
// bit-serial remainder unit, which shifts in one dividend bit per cycle. One
// candidate is in work at a time; a finished result waits in an output
// register while the next candidate is accepted.
module trial_division_prime_test #(
  parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] candidate,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                is_prime
);
  import tdpt_pkg::*;

  localparam int SW = VALUE_WIDTH + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]             state;
  logic [VALUE_WIDTH-1:0] n;
  logic [VALUE_WIDTH-1:0] d;
  logic [SW-1:0]          sq;
  logic                   res;
  logic [VALUE_WIDTH-1:0] n_in;
  logic                   rem_start;
  rem_status_t            rem_st;

  assign n_in      = VALUE_WIDTH'(candidate);
  assign in_ready  = (state == S_IDLE);
  assign rem_start = (state == S_CHECK) && (sq <= {2'b00, n});

  tdpt_rem #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_rem (
    .clk     (clk),
    .rst     (rst),
    .start   (rem_start),
    .dividend(n),
    .divisor (d),
    .status  (rem_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            n  <= n_in;
            d  <= VALUE_WIDTH'(2);
            sq <= SW'(4);
            if (n_in < VALUE_WIDTH'(2)) begin
              res   <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (rem_start) begin
            state <= S_DIV;
          end else begin
            res   <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DIV: begin
          if (rem_st.done) begin
            if (rem_st.zero) begin
              res   <= 1'b0;
              state <= S_DONE;
            end else begin
              d     <= d + VALUE_WIDTH'(1);
              sq    <= sq + SW'({d, 1'b1});
              state <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            is_prime  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    rem_st.done |-> (state == S_DIV))
    else $error("remainder finished outside the divide state");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_CHECK || state == S_DONE))
    else $error("accepted word did not start a test");

  a_divisor_min: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (d >= VALUE_WIDTH'(2) && rem_st.busy || rem_st.done))
    else $error("divide state without a running remainder");

endmodule
